// ===== design/lrfp_pkg.sv =====
// Package for the log record field parser: field phase and status codes,
// beat structs and the per-phase lookup functions. No dependencies.
package lrfp_pkg;

  localparam int unsigned LenBytes  = 4;
  localparam int unsigned TimeBytes = 8;
  localparam int unsigned TombBytes = 1;

  typedef enum logic [3:0] {
    PH_IDLEN    = 4'd0,
    PH_ID       = 4'd1,
    PH_TIME     = 4'd2,
    PH_VERSION  = 4'd3,
    PH_TOMB     = 4'd4,
    PH_DIM      = 4'd5,
    PH_VEC      = 4'd6,
    PH_METALEN  = 4'd7,
    PH_META     = 4'd8,
    PH_TAGCOUNT = 4'd9,
    PH_TAGLEN   = 4'd10,
    PH_TAG      = 4'd11,
    PH_TRAIL    = 4'd12
  } lrfp_phase_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_ROW      = 4'd1,
    ST_ID       = 4'd2,
    ST_HEADER   = 4'd3,
    ST_DIM      = 4'd4,
    ST_VECTOR   = 4'd5,
    ST_METALEN  = 4'd6,
    ST_META     = 4'd7,
    ST_TAGCOUNT = 4'd8,
    ST_TAGLEN   = 4'd9,
    ST_TAG      = 4'd10
  } lrfp_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_last;
  } lrfp_item_t;

  typedef struct packed {
    logic [7:0]   byte_out;
    lrfp_phase_e  field_kind;
    logic         field_end;
    logic [63:0]  field_value;
    logic         record_end;
    lrfp_status_e status;
  } lrfp_res_t;

  // Byte width of a numeric field; zero for byte-string phases and trailing.
  function automatic logic [3:0] num_width(lrfp_phase_e ph);
    logic [3:0] w;
    case (ph)
      PH_IDLEN, PH_DIM, PH_VEC, PH_METALEN,
      PH_TAGCOUNT, PH_TAGLEN:  w = 4'(LenBytes);
      PH_TIME, PH_VERSION:     w = 4'(TimeBytes);
      PH_TOMB:                 w = 4'(TombBytes);
      default:                 w = 4'd0;
    endcase
    return w;
  endfunction

  // Truncation code for a record that ends while the given field is expected.
  function automatic lrfp_status_e cut_status(lrfp_phase_e ph);
    lrfp_status_e s;
    case (ph)
      PH_IDLEN:                     s = ST_ROW;
      PH_ID:                        s = ST_ID;
      PH_TIME, PH_VERSION, PH_TOMB: s = ST_HEADER;
      PH_DIM:                       s = ST_DIM;
      PH_VEC:                       s = ST_VECTOR;
      PH_METALEN:                   s = ST_METALEN;
      PH_META:                      s = ST_META;
      PH_TAGCOUNT:                  s = ST_TAGCOUNT;
      PH_TAGLEN:                    s = ST_TAGLEN;
      PH_TAG:                       s = ST_TAG;
      default:                      s = ST_OK;
    endcase
    return s;
  endfunction

endpackage

// ===== design/lrfp_in_stage.sv =====
// Input register of the log record field parser: holds one incoming beat
// until the parser takes it. Depends on lrfp_pkg.
module lrfp_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                record_last_i,
  input  logic                take_i,
  output logic                item_valid_o,
  output lrfp_pkg::lrfp_item_t item_o
);
  import lrfp_pkg::*;

  logic       vld_q, vld_d;
  lrfp_item_t item_q;
  logic       load;

  // The register may refill in the same cycle as its beat moves on.
  assign load       = !vld_q || take_i;
  assign in_stall_o = !load;
  assign vld_d      = load ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q.data_byte   <= data_byte_i;
      item_q.record_last <= record_last_i;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

// ===== design/lrfp_parser.sv =====
// Field state machine of the log record field parser: classifies one byte,
// assembles numeric fields and reports truncation. Depends on lrfp_pkg.
module lrfp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  lrfp_pkg::lrfp_item_t item_i,
  output lrfp_pkg::lrfp_res_t  res_o
);
  import lrfp_pkg::*;

  lrfp_phase_e  phase_q, phase_d;
  logic [2:0]   bif_q, bif_d;
  logic [31:0]  bl_q, bl_d;
  logic [31:0]  il_q, il_d;
  logic [63:0]  acc_q, acc_d;

  logic [63:0]  acc_or;
  logic [3:0]   bif_inc;
  logic [3:0]   width;
  logic [31:0]  bl_dec;
  logic [31:0]  il_dec;
  logic         fend;
  logic [63:0]  fval;
  lrfp_status_e status;

  always_comb begin
    acc_or  = acc_q | ({56'd0, item_i.data_byte} << {bif_q, 3'b000});
    bif_inc = {1'b0, bif_q} + 4'd1;
    width   = num_width(phase_q);
    bl_dec  = (bl_q != 32'd0) ? bl_q - 32'd1 : 32'd0;
    il_dec  = (il_q != 32'd0) ? il_q - 32'd1 : 32'd0;

    phase_d = phase_q;
    bif_d   = bif_q;
    bl_d    = bl_q;
    il_d    = il_q;
    acc_d   = acc_q;
    fend    = 1'b0;
    fval    = 64'd0;
    status  = ST_OK;

    if (width != 4'd0) begin
      if (bif_inc >= width) begin
        fend  = 1'b1;
        fval  = acc_or;
        acc_d = 64'd0;
        bif_d = 3'd0;
        case (phase_q)
          PH_IDLEN: begin
            bl_d    = acc_or[31:0];
            phase_d = (acc_or[31:0] != 32'd0) ? PH_ID : PH_TIME;
          end
          PH_TIME:    phase_d = PH_VERSION;
          PH_VERSION: phase_d = PH_TOMB;
          PH_TOMB:    phase_d = PH_DIM;
          PH_DIM: begin
            il_d    = acc_or[31:0];
            phase_d = (acc_or[31:0] != 32'd0) ? PH_VEC : PH_METALEN;
          end
          PH_VEC: begin
            il_d = il_dec;
            if (il_dec == 32'd0) begin
              phase_d = PH_METALEN;
            end
          end
          PH_METALEN: begin
            bl_d    = acc_or[31:0];
            phase_d = (acc_or[31:0] != 32'd0) ? PH_META : PH_TAGCOUNT;
          end
          PH_TAGCOUNT: begin
            il_d    = acc_or[31:0];
            phase_d = (acc_or[31:0] != 32'd0) ? PH_TAGLEN : PH_TRAIL;
          end
          PH_TAGLEN: begin
            bl_d = acc_or[31:0];
            if (acc_or[31:0] != 32'd0) begin
              phase_d = PH_TAG;
            end else begin
              // An empty tag counts as done straight away.
              il_d    = il_dec;
              phase_d = (il_dec != 32'd0) ? PH_TAGLEN : PH_TRAIL;
            end
          end
          default: phase_d = phase_q;
        endcase
      end else begin
        acc_d = acc_or;
        bif_d = bif_inc[2:0];
      end
    end else if (phase_q == PH_ID || phase_q == PH_META || phase_q == PH_TAG) begin
      bl_d = bl_dec;
      if (bl_dec == 32'd0) begin
        case (phase_q)
          PH_ID:   phase_d = PH_TIME;
          PH_META: phase_d = PH_TAGCOUNT;
          default: begin
            il_d    = il_dec;
            phase_d = (il_dec != 32'd0) ? PH_TAGLEN : PH_TRAIL;
          end
        endcase
      end
    end else begin
      phase_d = PH_TRAIL;
    end

    // The status names the field that was expected after the last byte.
    if (item_i.record_last) begin
      status  = cut_status(phase_d);
      phase_d = PH_IDLEN;
      bif_d   = 3'd0;
      bl_d    = 32'd0;
      il_d    = 32'd0;
      acc_d   = 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLEN;
      bif_q   <= 3'd0;
      bl_q    <= 32'd0;
      il_q    <= 32'd0;
      acc_q   <= 64'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bif_q   <= bif_d;
      bl_q    <= bl_d;
      il_q    <= il_d;
      acc_q   <= acc_d;
    end
  end

  assign res_o.byte_out    = item_i.data_byte;
  assign res_o.field_kind  = phase_q;
  assign res_o.field_end   = fend;
  assign res_o.field_value = fval;
  assign res_o.record_end  = item_i.record_last;
  assign res_o.status      = status;

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.record_last |=> phase_q == PH_IDLEN && bl_q == 32'd0 && il_q == 32'd0)
    else $error("parser state not cleared after record end");

  a_partial_numeric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bif_q != 3'd0 |-> num_width(phase_q) != 4'd0 && acc_q != 64'd0 || bif_q != 3'd0 &&
    num_width(phase_q) != 4'd0)
    else $error("partial byte count outside a numeric field");

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bif_q == 3'd0 |-> acc_q == 64'd0)
    else $error("accumulator holds bits at the start of a field");

  a_vec_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_VEC |-> il_q != 32'd0)
    else $error("vector phase with no words left");

  a_bytes_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ID || phase_q == PH_META || phase_q == PH_TAG |-> bl_q != 32'd0)
    else $error("byte-string phase with no bytes left");

endmodule

// ===== design/lrfp_out_stage.sv =====
// Result register of the log record field parser: holds a finished beat
// until the downstream side takes it. Depends on lrfp_pkg.
module lrfp_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  lrfp_pkg::lrfp_res_t res_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output lrfp_pkg::lrfp_res_t res_o
);
  import lrfp_pkg::*;

  logic      vld_q, vld_d;
  lrfp_res_t res_q;

  always_comb begin
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_stall_i) begin
      vld_d = vld_q;
    end else begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

// ===== design/log_record_field_parser_top.sv =====
// Top level of the log record field parser: input register, field state
// machine and result register. Depends on lrfp_pkg and the lrfp_* modules.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+---------------------------------------
//   in      | in_valid_i  | in_stall_o  | data_byte_i, record_last_i
//   out     | out_valid_o | out_stall_i | byte_out_o, field_kind_o, field_end_o,
//           |             |             | field_value_o, record_end_o, status_o
//
// One beat per cycle is taken and one result per cycle is given while the output does
// not stall; the parse lies between the input register and the result register.
// The field state updates once per beat as the beat moves into the result register.
// A stall on the output holds the result register and backs up into the input
// register; the input stalls only once both registers are full.
// Reset clears the valid flags and returns the parser to the id length field.
module log_record_field_parser_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  record_last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            byte_out_o,
  output logic [3:0]            field_kind_o,
  output logic                  field_end_o,
  output logic [63:0]           field_value_o,
  output logic                  record_end_o,
  output logic [3:0]            status_o
);
  import lrfp_pkg::*;

  logic       item_valid;
  lrfp_item_t item;
  logic       step;
  lrfp_res_t  res_next;
  lrfp_res_t  res;

  // A beat moves on when the result register is empty or being drained.
  assign step = item_valid && (!out_valid_o || !out_stall_i);

  lrfp_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .record_last_i (record_last_i),
    .take_i        (step),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  lrfp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .res_o  (res_next)
  );

  lrfp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res_next),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign byte_out_o    = res.byte_out;
  assign field_kind_o  = res.field_kind;
  assign field_end_o   = res.field_end;
  assign field_value_o = res.field_value;
  assign record_end_o  = res.record_end;
  assign status_o      = res.status;

endmodule
